@@ hdl/min_priority_queue_drain_core_macros.svh @@
// assertion macros used by the queue controller rtl
`ifndef MIN_PRIORITY_QUEUE_DRAIN_CORE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_DRAIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MPQD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define MPQD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MPQD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MPQD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/mpqd_pkg.sv @@
package mpqd_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CAP_W = 5;
	localparam int SEQ_W = 5;
	localparam int KEY_W = 8;
	localparam int STAMP_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic add_en;
		logic [IDX_W-1:0] add_pos;
		entry_t add_entry;
		logic shift_en;
		logic ins_en;
		logic [IDX_W-1:0] ins_pos;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_SHIFT
	} state_t;
endpackage

@@ hdl/min_priority_queue_drain_core.sv @@
// add: no result; the queue accepts while a result waits
// drain: each result is found by a scan that rotates the cell ring, then an
// emit once the output register is free, then a second rotation that drops
// the winner; the last result of a drain skips the second rotation
// reset: entry count cleared, capacity back to 16, cell contents not reset
module min_priority_queue_drain_core import mpqd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic opcode,
	input logic [KEY_W-1:0] priority_key,
	input logic [STAMP_W-1:0] stamp,
	input logic cfg_wr_en,
	input logic [CAP_W-1:0] cfg_wr_data,
	output logic out_valid,
	input logic out_ready,
	output logic [SEQ_W-1:0] sequence_number,
	output logic [KEY_W-1:0] out_key,
	output logic [STAMP_W-1:0] out_stamp,
	output logic last_of_drain
);
	// the cells form a ring: cell 0 is the head seen by the sequencer,
	// every other cell hands its entry one place down each shift cycle
	cell_ctrl_t cell_ctrl;
	entry_t cell_entry [QUEUE_DEPTH];
	entry_t head;

	assign head = cell_entry[0];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			// on a shift the last cell refills from the head
			assign nxt = head;
		end else begin : g_body
			assign nxt = cell_entry[i+1];
		end
		mpqd_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(i)),
			.ctrl  (cell_ctrl),
			.head  (head),
			.nxt   (nxt),
			.entry (cell_entry[i])
		);
	end

	// sequencer: capacity register, entry count, scan for the minimum,
	// output register so the next transaction can come in while one waits
	mpqd_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.priority_key    (priority_key),
		.stamp           (stamp),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.head            (head),
		.cell_ctrl       (cell_ctrl),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sequence_number (sequence_number),
		.out_key         (out_key),
		.out_stamp       (out_stamp),
		.last_of_drain   (last_of_drain)
	);
endmodule

@@ hdl/mpqd_cell.sv @@
module mpqd_cell import mpqd_pkg::*; (
	input logic clk,
	input logic [IDX_W-1:0] idx,
	input cell_ctrl_t ctrl,
	input entry_t head,
	input entry_t nxt,
	output entry_t entry
);
	entry_t entry_q;

	// add writes the tail, a shift moves one place towards the head,
	// the cell at the insert position takes the head back
	always_ff @(posedge clk) begin
		if (ctrl.add_en && ctrl.add_pos == idx) begin
			entry_q <= ctrl.add_entry;
		end else if (ctrl.shift_en) begin
			if (ctrl.ins_en && ctrl.ins_pos == idx) begin
				entry_q <= head;
			end else begin
				entry_q <= nxt;
			end
		end
	end

	assign entry = entry_q;
endmodule

@@ hdl/mpqd_ctrl.sv @@
`include "min_priority_queue_drain_core_macros.svh"
module mpqd_ctrl import mpqd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic opcode,
	input logic [KEY_W-1:0] priority_key,
	input logic [STAMP_W-1:0] stamp,
	input logic cfg_wr_en,
	input logic [CAP_W-1:0] cfg_wr_data,
	input entry_t head,
	output cell_ctrl_t cell_ctrl,
	output logic out_valid,
	input logic out_ready,
	output logic [SEQ_W-1:0] sequence_number,
	output logic [KEY_W-1:0] out_key,
	output logic [STAMP_W-1:0] out_stamp,
	output logic last_of_drain
);
	state_t state_q, state_nxt;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pass_len_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t best_q;
	logic [SEQ_W-1:0] seq_q;
	logic out_valid_q;
	logic [SEQ_W-1:0] out_seq_q;
	entry_t out_entry_q;
	logic out_last_q;

	logic accept;
	logic full;
	logic last_step;
	logic out_free;

	assign accept = in_valid && in_ready;
	assign full = (32'(count_q) >= 32'(capacity_q)) || (32'(count_q) >= QUEUE_DEPTH);
	assign last_step = CNT_W'(step_q) == pass_len_q - CNT_W'(1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_DRAIN && count_q != '0) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_step) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_nxt = (count_q == CNT_W'(1)) ? ST_IDLE : ST_SHIFT;
			end
			ST_SHIFT: begin
				if (last_step) state_nxt = ST_SCAN;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cell_ctrl = '0;
		cell_ctrl.add_pos = count_q[IDX_W-1:0];
		cell_ctrl.add_entry = '{key: priority_key, stamp: stamp};
		cell_ctrl.ins_pos = IDX_W'(count_q - CNT_W'(1));
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cell_ctrl.add_en = in_valid && opcode == OP_ADD && !full;
			end
			ST_SCAN: begin
				cell_ctrl.shift_en = 1'b1;
				cell_ctrl.ins_en = 1'b1;
			end
			ST_SHIFT: begin
				cell_ctrl.shift_en = 1'b1;
				cell_ctrl.ins_en = step_q != best_idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			capacity_q <= CAP_RESET;
			count_q <= '0;
			pass_len_q <= '0;
			step_q <= '0;
			seq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) capacity_q <= cfg_wr_data;
			if (out_valid_q && out_ready && state_q != ST_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_ADD) begin
							if (!full) count_q <= count_q + CNT_W'(1);
						end else begin
							seq_q <= '0;
							step_q <= '0;
							pass_len_q <= count_q;
						end
					end
				end
				ST_SCAN: begin
					step_q <= last_step ? '0 : step_q + IDX_W'(1);
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						seq_q <= seq_q + SEQ_W'(1);
						if (count_q == CNT_W'(1)) count_q <= '0;
					end
				end
				ST_SHIFT: begin
					if (step_q == best_idx_q) count_q <= count_q - CNT_W'(1);
					if (last_step) begin
						step_q <= '0;
						pass_len_q <= pass_len_q - CNT_W'(1);
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// running minimum over the scan, strict compare keeps the earliest on a tie
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && (step_q == '0 || head.key < best_q.key)) begin
			best_q <= head;
			best_idx_q <= step_q;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_seq_q <= seq_q + SEQ_W'(1);
			out_entry_q <= best_q;
			out_last_q <= count_q == CNT_W'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign sequence_number = out_seq_q;
	assign out_key = out_entry_q.key;
	assign out_stamp = out_entry_q.stamp;
	assign last_of_drain = out_last_q;

	`MPQD_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, 32'(count_q) <= QUEUE_DEPTH)
	`MPQD_ASSERT_IMP(a_busy_nonempty, clk, arst_n, state_q == ST_SCAN || state_q == ST_SHIFT, count_q != '0)
	`MPQD_ASSERT_NXT(a_emit_loads, clk, arst_n, state_q == ST_EMIT && out_free, out_valid_q)
	`MPQD_ASSERT_NXT(a_last_empties, clk, arst_n, state_q == ST_EMIT && out_free && count_q == CNT_W'(1), state_q == ST_IDLE && count_q == '0)
endmodule

@@ tb/tb.sv @@
module tb import mpqd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// cycles allowed after the last result before a register write or the end
	localparam int SETTLE_CYCLES = 8;
	// long receiver back-off so the block fills and stops taking transactions
	localparam int HOLD_CYCLES = 600;
	// well above the slowest correct run, full drains and stalls included
	localparam int CYCLE_LIMIT = 400000;

	// one job offered on the input channel
	typedef struct {
		logic op;
		logic [KEY_W-1:0] key;
		logic [STAMP_W-1:0] stamp;
	} job_t;

	// one job as it should leave the queue
	typedef struct {
		logic [SEQ_W-1:0] seq;
		logic [KEY_W-1:0] key;
		logic [STAMP_W-1:0] stamp;
		logic last;
	} served_job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_ADD;
	logic [KEY_W-1:0] priority_key = '0;
	logic [STAMP_W-1:0] stamp = '0;
	logic cfg_wr_en = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SEQ_W-1:0] sequence_number;
	logic [KEY_W-1:0] out_key;
	logic [STAMP_W-1:0] out_stamp;
	logic last_of_drain;

	// jobs waiting to be offered, filled by the stimulus block
	job_t pending_jobs[$];
	job_t next_job;
	// jobs the queue should serve, oldest first
	served_job_t served_expect[$];

	// shadow copy of the queue contents and the capacity register
	logic [KEY_W-1:0] shadow_keys[QUEUE_DEPTH];
	logic [STAMP_W-1:0] shadow_stamps[QUEUE_DEPTH];
	int shadow_count = 0;
	logic [CAP_W-1:0] shadow_cap = CAP_RESET;

	int tx_idle_pct = 9;
	int rx_idle_pct = 52;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int fail_count = 0;

	min_priority_queue_drain_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.priority_key(priority_key),
		.stamp(stamp),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sequence_number(sequence_number),
		.out_key(out_key),
		.out_stamp(out_stamp),
		.last_of_drain(last_of_drain)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one accepted job to the shadow queue; a drain yields every
	// stored job, smallest key first, earliest insert first on a tie
	function automatic void queue_accept(input logic op, input logic [KEY_W-1:0] key,
			input logic [STAMP_W-1:0] stamp_in);
		int limit;
		int best;
		int served;
		int i;
		served_job_t job;
		limit = (int'(shadow_cap) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(shadow_cap);
		if (op == OP_ADD) begin
			// a full queue, capacity zero included, drops the job quietly
			if (shadow_count < limit) begin
				shadow_keys[shadow_count] = key;
				shadow_stamps[shadow_count] = stamp_in;
				shadow_count++;
			end
			return;
		end
		// drain fields are ignored, an empty queue gives nothing
		served = 0;
		while (shadow_count > 0) begin
			best = 0;
			for (i = 1; i < shadow_count; i++)
				if (shadow_keys[i] < shadow_keys[best])
					best = i;
			served++;
			job.seq = SEQ_W'(served);
			job.key = shadow_keys[best];
			job.stamp = shadow_stamps[best];
			job.last = (shadow_count == 1);
			served_expect.push_back(job);
			// close the gap left by the winner
			for (i = best; i + 1 < shadow_count; i++) begin
				shadow_keys[i] = shadow_keys[i + 1];
				shadow_stamps[i] = shadow_stamps[i + 1];
			end
			shadow_count--;
		end
	endfunction

	// sender: the shadow queue is updated on each accepted transaction,
	// the next job is loaded only once the channel is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_ADD;
			priority_key <= '0;
			stamp <= '0;
		end else begin
			if (in_valid && in_ready)
				queue_accept(opcode, priority_key, stamp);
			if (!in_valid || in_ready) begin
				if (pending_jobs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_job = pending_jobs.pop_front();
					in_valid <= 1'b1;
					opcode <= next_job.op;
					priority_key <= next_job.key;
					stamp <= next_job.stamp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver back-off, counted here so the sender keeps going
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: every served job is checked against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (served_expect.size() == 0) begin
					$display("%0t: unexpected job served, key %0d stamp %0d seq %0d",
						$time, out_key, out_stamp, sequence_number);
					fail_count++;
				end else begin
					if (sequence_number !== served_expect[0].seq) begin
						$display("%0t: sequence_number expected %0d actual %0d",
							$time, served_expect[0].seq, sequence_number);
						fail_count++;
					end
					if (out_key !== served_expect[0].key) begin
						$display("%0t: out_key expected %0d actual %0d",
							$time, served_expect[0].key, out_key);
						fail_count++;
					end
					if (out_stamp !== served_expect[0].stamp) begin
						$display("%0t: out_stamp expected %h actual %h",
							$time, served_expect[0].stamp, out_stamp);
						fail_count++;
					end
					if (last_of_drain !== served_expect[0].last) begin
						$display("%0t: last_of_drain expected %b actual %b",
							$time, served_expect[0].last, last_of_drain);
						fail_count++;
					end
					void'(served_expect.pop_front());
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not complete in %0d cycles", $time, CYCLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic add_job(input logic [KEY_W-1:0] key, input logic [STAMP_W-1:0] stamp_in);
		job_t job;
		job.op = OP_ADD;
		job.key = key;
		job.stamp = stamp_in;
		pending_jobs.push_back(job);
	endtask

	// drain carries random fields, which the block must ignore
	task automatic drain_all;
		job_t job;
		job.op = OP_DRAIN;
		job.key = KEY_W'($urandom);
		job.stamp = $urandom;
		pending_jobs.push_back(job);
	endtask

	// wait until every job is offered and served, then let adds settle
	task automatic wait_quiet;
		do @(negedge clk);
		while (pending_jobs.size() != 0 || in_valid || served_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only called with the block quiet
	task automatic set_capacity(input logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_cap = value;
		@(negedge clk);
	endtask

	initial begin
		int chunk;
		int n;
		logic [STAMP_W-1:0] rnd_stamp;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset capacity: empty drain, extremes, ties on key resolved by insert order
		drain_all();
		add_job(8'hff, 32'hffff_ffff);
		add_job(8'h00, 32'h0000_0000);
		add_job(8'd7, 32'd1);
		add_job(8'd7, 32'd2);
		add_job(8'h00, 32'd5);
		drain_all();
		wait_quiet();

		// capacity one: second add dropped
		set_capacity(5'd1);
		add_job(8'd3, 32'h1234_5678);
		add_job(8'd4, 32'h8765_4321);
		drain_all();
		wait_quiet();

		// capacity zero: queue always full
		set_capacity(5'd0);
		add_job(8'd9, 32'h5555_aaaa);
		drain_all();
		wait_quiet();

		// capacity lowered below the count: stored jobs stay, new ones dropped
		set_capacity(5'd16);
		add_job(8'd40, 32'd100);
		add_job(8'd20, 32'd200);
		add_job(8'd40, 32'd300);
		add_job(8'd10, 32'hdead_beef);
		wait_quiet();
		set_capacity(5'd2);
		add_job(8'd1, 32'd400);
		drain_all();
		wait_quiet();

		// capacity above depth saturates; receiver backs off long enough for
		// the block to fill and stop accepting while jobs keep coming
		set_capacity(5'd31);
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		for (n = 0; n < 17; n++)
			add_job(KEY_W'($urandom_range(15)), $urandom);
		drain_all();
		for (n = 0; n < 16; n++)
			add_job(KEY_W'($urandom), $urandom);
		drain_all();
		wait_quiet();

		// random chunks, new capacity each time; small keys for plenty of ties
		for (chunk = 0; chunk < 6; chunk++) begin
			if (chunk == 2) begin
				tx_idle_pct = 52;
				rx_idle_pct = 9;
			end else if (chunk == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			wait_quiet();
			if ($urandom_range(7) == 0)
				set_capacity(CAP_W'($urandom_range(31)));
			else
				set_capacity(CAP_W'($urandom_range(16, 1)));
			for (n = 0; n < 24; n++) begin
				if ($urandom_range(99) < 12) begin
					drain_all();
				end else begin
					case ($urandom_range(7))
						0: rnd_stamp = '0;
						1: rnd_stamp = '1;
						default: rnd_stamp = $urandom;
					endcase
					if ($urandom_range(1) == 0)
						add_job(KEY_W'($urandom_range(3)), rnd_stamp);
					else
						add_job(KEY_W'($urandom), rnd_stamp);
				end
			end
			drain_all();
		end

		wait_quiet();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
